[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/core/olie_pkg.sv]
// ----------------------------------------------------------------------------
// olie_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olie_pkg;

  localparam int CAPACITY   = 32;
  localparam int STORE_MAX  = 32;
  localparam int LIST_LIMIT = (CAPACITY < STORE_MAX) ? CAPACITY : STORE_MAX;
  localparam int CNT_W      = $clog2(LIST_LIMIT + 1);
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 5;
  localparam int POS_W      = 6;
  localparam int CMD_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_DELETE     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DUMP
  } state_e;

  typedef enum logic [1:0] {
    SEL_LEFT,
    SEL_RIGHT,
    SEL_HEAD,
    SEL_NEW
  } cell_sel_e;

  typedef struct packed {
    logic      en;
    cell_sel_e sel;
  } cell_ctrl_t;

endpackage

[rtl/core/olie_cell.sv]
// ----------------------------------------------------------------------------
// olie_cell
// One list slot: holds a value and loads from a neighbor, the head or a new value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olie_cell
  import olie_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  input  logic signed [VAL_W-1:0] head_i,
  input  logic signed [VAL_W-1:0] new_i,
  output logic signed [VAL_W-1:0] value_o
);

  logic signed [VAL_W-1:0] value_q;
  logic signed [VAL_W-1:0] value_d;

  always_comb begin
    case (ctrl_i.sel)
      SEL_LEFT:  value_d = left_i;
      SEL_RIGHT: value_d = right_i;
      SEL_HEAD:  value_d = head_i;
      SEL_NEW:   value_d = new_i;
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

[rtl/core/ordered_list_insert_delete_engine_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_engine_unit
// Ordered list of signed values with front insert, back append and indexed delete.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel carries a command, a value and a position.
// The block applies it to the list held in a row of cells and then streams the
// whole list on the m_axis channel, front first, with tlast on the final item.
// An empty list gives one item with the empty flag set in tuser.
// An insert into a full list leaves the list as it was and sets the dropped flag
// in tuser on every item of that dump.
// A request is accepted in ST_IDLE, its cells are updated in ST_APPLY and the
// list is then streamed in ST_DUMP, one item per list entry (at least one), as
// the receiver takes them; the dump walks the list by rotating the cell row one
// place per item. A new request is accepted once the last item has been loaded
// into the output register, while that item still waits to be taken.
// When the receiver stalls, the output register and the cell row hold still.
// Reset empties the list and drops any item held in the output register; the
// cell contents are not cleared and are never read beyond the entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ordered_list_insert_delete_engine_unit
  import olie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cmd[1:0], value[33:2], position[39:34]
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // item_value[31:0], item_index[36:32], zero fill[39:37]
  output logic [39:0] m_axis_tdata_o,
  // list_empty[0], insert_dropped[1]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  state_e state_q, state_d;

  logic [CMD_W-1:0]        cmd_q;
  logic signed [VAL_W-1:0] val_q;
  logic [POS_W-1:0]        pos_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    dropped_q, dropped_d;
  logic [IDX_W-1:0]        idx_q, idx_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_val_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic                    out_empty_q;
  logic                    out_drop_q;
  logic                    out_last_q;

  logic                    in_fire;
  logic                    load;
  logic                    full;
  logic                    del_ok;
  logic                    dump_last;
  logic [CNT_W-1:0]        cnt_last;

  cell_ctrl_t              ctrl [LIST_LIMIT];
  logic signed [VAL_W-1:0] cell_val [LIST_LIMIT];

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign full      = (count_q == CNT_W'(LIST_LIMIT));
  assign del_ok    = (pos_q < POS_W'(count_q));
  assign cnt_last  = count_q - CNT_W'(1);
  assign dump_last = ((POS_W'(idx_q) + POS_W'(1)) == POS_W'(count_q));

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    dropped_d       = dropped_q;
    idx_d           = idx_q;
    load            = 1'b0;
    s_axis_tready_o = 1'b0;
    for (int i = 0; i < LIST_LIMIT; i++) begin
      ctrl[i] = '{en: 1'b0, sel: SEL_RIGHT};
    end
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        dropped_d = 1'b0;
        idx_d     = '0;
        state_d   = ST_DUMP;
        case (cmd_q)
          CMD_PUSH_FRONT: begin
            if (full) begin
              dropped_d = 1'b1;
            end else begin
              count_d = count_q + CNT_W'(1);
              for (int i = 0; i < LIST_LIMIT; i++) begin
                ctrl[i] = '{en: 1'b1, sel: (i == 0) ? SEL_NEW : SEL_LEFT};
              end
            end
          end
          CMD_PUSH_BACK: begin
            if (full) begin
              dropped_d = 1'b1;
            end else begin
              count_d = count_q + CNT_W'(1);
              for (int i = 0; i < LIST_LIMIT; i++) begin
                ctrl[i] = '{en: (CNT_W'(i) == count_q), sel: SEL_NEW};
              end
            end
          end
          CMD_DELETE: begin
            if (del_ok) begin
              count_d = count_q - CNT_W'(1);
              for (int i = 0; i < LIST_LIMIT; i++) begin
                ctrl[i] = '{en: (POS_W'(i) >= pos_q), sel: SEL_RIGHT};
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_DUMP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load = 1'b1;
          if (count_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
            for (int i = 0; i < LIST_LIMIT; i++) begin
              ctrl[i] = '{en:  (CNT_W'(i) < count_q),
                          sel: (CNT_W'(i) == cnt_last) ? SEL_HEAD : SEL_RIGHT};
            end
            if (dump_last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < LIST_LIMIT; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == LIST_LIMIT - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    olie_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (cell_val[0]),
      .new_i   (val_q),
      .value_o (cell_val[g])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tdata_i[CMD_W-1:0];
      val_q <= s_axis_tdata_i[CMD_W+VAL_W-1:CMD_W];
      pos_q <= s_axis_tdata_i[CMD_W+VAL_W+POS_W-1:CMD_W+VAL_W];
    end
    if (load) begin
      out_empty_q <= (count_q == '0);
      out_drop_q  <= dropped_q;
      out_idx_q   <= idx_q;
      out_val_q   <= (count_q == '0) ? '0 : cell_val[0];
      out_last_q  <= (count_q == '0) || dump_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_idx_q, out_val_q};
  assign m_axis_tuser_o  = {out_drop_q, out_empty_q};
  assign m_axis_tlast_o  = out_last_q;

  `ASSERT_NEVER(a_count_range, count_q > CNT_W'(LIST_LIMIT), "entry count above limit")
  `ASSERT_CLK(a_accept_apply, in_fire |=> (state_q == ST_APPLY), "request not applied")
  `ASSERT_CLK(a_apply_dump, (state_q == ST_APPLY) |=> (state_q == ST_DUMP),
              "apply not followed by dump")
  `ASSERT_CLK(a_empty_last, (out_valid_q && out_empty_q) |-> out_last_q,
              "empty item without tlast")

endmodule

[bench/tb_ordered_list_insert_delete_engine_unit.sv]
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete_engine_unit
// Self-checking bench for the ordered list engine.
// ----------------------------------------------------------------------------
// Requests are sent over the s_axis channel with random gaps. A shadow list in
// the bench applies each accepted request and queues the dump that the block
// must then stream. A checker compares every m_axis item, field by field,
// against the oldest queued entry while the receiver stalls at random.
// Directed requests cover the empty list, extreme values, every command, and
// out-of-range deletes. Random requests then fill the list to capacity, try
// inserts into the full list, and churn between growing and draining.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete_engine_unit;
  import olie_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 2 * LIST_LIMIT + 8;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             empty;
    logic             dropped;
    logic             last;
  } dump_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  logic [VAL_W-1:0] shadow_vals [LIST_LIMIT];
  int               shadow_len;
  dump_item_t       dump_q [$];

  bit gaps_on;
  int mismatches;
  int cycle_cnt;
  int n_front, n_back, n_delete, n_unused, n_dropped, n_items_checked, max_len;

  ordered_list_insert_delete_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** ordered_list_insert_delete_engine_unit: FAILED **");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= !(gaps_on && ($urandom_range(0, 99) < 29));
  end

  task automatic apply_to_shadow_list(input logic [CMD_W-1:0] cmd,
                                      input logic [VAL_W-1:0] val,
                                      input logic [POS_W-1:0] pos);
    logic       dropped;
    dump_item_t item;
    dropped = 1'b0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_len >= LIST_LIMIT) begin
          dropped = 1'b1;
          n_dropped++;
        end else if (cmd == CMD_PUSH_FRONT) begin
          for (int i = shadow_len; i > 0; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[0] = val;
          shadow_len++;
        end else begin
          shadow_vals[shadow_len] = val;
          shadow_len++;
        end
        if (cmd == CMD_PUSH_FRONT) n_front++;
        else n_back++;
      end
      CMD_DELETE: begin
        n_delete++;
        if (int'(pos) < shadow_len) begin
          for (int i = int'(pos); i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
        end
      end
      default: n_unused++;
    endcase
    if (shadow_len > max_len) max_len = shadow_len;
    if (shadow_len == 0) begin
      item = '{value: '0, index: '0, empty: 1'b1, dropped: dropped, last: 1'b1};
      dump_q.push_back(item);
    end else begin
      for (int i = 0; i < shadow_len; i++) begin
        item = '{value: shadow_vals[i], index: IDX_W'(i), empty: 1'b0,
                 dropped: dropped, last: (i + 1 == shadow_len)};
        dump_q.push_back(item);
      end
    end
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    @(negedge clk_i);
    while (gaps_on && ($urandom_range(0, 99) < 29)) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pos, val, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_to_shadow_list(cmd, val, pos);
  endtask

  task automatic wait_for_dumps;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (dump_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (shadow_len > 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(0, shadow_len - 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  always @(posedge clk_i) begin : check_dump
    dump_item_t exp_item;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_items_checked++;
      if (dump_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] item with nothing expected: value=%h index=%0d user=%b last=%b",
                   $realtime, m_axis_tdata_o[31:0], m_axis_tdata_o[36:32],
                   m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        exp_item = dump_q.pop_front();
        if (m_axis_tdata_o[31:0] !== exp_item.value || m_axis_tdata_o[36:32] !== exp_item.index ||
            m_axis_tuser_o[0] !== exp_item.empty || m_axis_tuser_o[1] !== exp_item.dropped ||
            m_axis_tlast_o !== exp_item.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] mismatch: expected value=%h index=%0d empty=%b dropped=%b last=%b",
                     $realtime, exp_item.value, exp_item.index, exp_item.empty,
                     exp_item.dropped, exp_item.last);
            $display("    got value=%h index=%0d empty=%b dropped=%b last=%b",
                     m_axis_tdata_o[31:0], m_axis_tdata_o[36:32], m_axis_tuser_o[0],
                     m_axis_tuser_o[1], m_axis_tlast_o);
          end
        end
      end
    end
  end

  task automatic test_empty_list;
    send_request(CMD_DELETE, 32'h0, 6'd0);
    send_request(CMD_DELETE, 32'hFFFF_FFFF, 6'd63);
    send_request(CMD_UNUSED, 32'h1234_5678, 6'd5);
  endtask

  task automatic test_edit_commands;
    send_request(CMD_PUSH_BACK,  32'h7FFF_FFFF, 6'd0);
    send_request(CMD_PUSH_FRONT, 32'h8000_0000, 6'd63);
    send_request(CMD_PUSH_BACK,  32'h0000_0000, 6'd0);
    send_request(CMD_PUSH_BACK,  32'hFFFF_FFFF, 6'd0);
    send_request(CMD_PUSH_FRONT, 32'h5555_5555, 6'd0);
    send_request(CMD_PUSH_BACK,  32'hAAAA_AAAA, 6'd0);
    send_request(CMD_DELETE,     32'h0, 6'd6);
    send_request(CMD_DELETE,     32'h0, 6'd32);
    send_request(CMD_DELETE,     32'h0, 6'd63);
    send_request(CMD_DELETE,     32'h0, 6'd5);
    send_request(CMD_DELETE,     32'h0, 6'd0);
    send_request(CMD_DELETE,     32'h0, 6'd1);
    send_request(CMD_UNUSED,     32'hDEAD_BEEF, 6'd2);
  endtask

  task automatic test_only_entry_removal;
    send_request(CMD_DELETE,     32'h0, 6'd0);
    send_request(CMD_DELETE,     32'h0, 6'd0);
    send_request(CMD_DELETE,     32'h0, 6'd0);
    send_request(CMD_PUSH_FRONT, 32'h0000_0001, 6'd0);
    send_request(CMD_DELETE,     32'h0, 6'd0);
    send_request(CMD_PUSH_BACK,  32'h0000_0007, 6'd0);
    send_request(CMD_PUSH_FRONT, 32'h0000_0008, 6'd0);
    wait_for_dumps();
  endtask

  task automatic test_full_list;
    while (shadow_len < LIST_LIMIT)
      send_request($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value(),
                   POS_W'($urandom_range(0, 63)));
    send_request(CMD_PUSH_FRONT, pick_value(), 6'd0);
    send_request(CMD_PUSH_BACK,  pick_value(), 6'd0);
    send_request(CMD_DELETE,     32'h0, POS_W'(LIST_LIMIT - 1));
    send_request(CMD_PUSH_BACK,  pick_value(), 6'd0);
    send_request(CMD_DELETE,     32'h0, 6'd0);
    send_request(CMD_PUSH_FRONT, pick_value(), 6'd0);
    send_request(CMD_PUSH_BACK,  pick_value(), 6'd0);
    send_request(CMD_DELETE,     32'h0, 6'd63);
  endtask

  task automatic test_random_churn;
    bit growing;
    int pick;
    growing = 1'b0;
    for (int k = 0; k < 215; k++) begin
      if (k == 70) gaps_on = 1'b0;
      if (k == 100) wait_for_dumps();
      if (k == 135) gaps_on = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3)
        send_request(CMD_UNUSED, pick_value(), POS_W'($urandom_range(0, 63)));
      else if (pick < (growing ? 78 : 25))
        send_request($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value(),
                     POS_W'($urandom_range(0, 63)));
      else
        send_request(CMD_DELETE, pick_value(), pick_position());
      if (shadow_len == LIST_LIMIT && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (shadow_len == 0) growing = 1'b1;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    gaps_on         = 1'b1;
    cycle_cnt       = 0;
    mismatches      = 0;
    shadow_len      = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_edit_commands();
    test_only_entry_removal();
    test_full_list();
    test_random_churn();

    wait_for_dumps();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (dump_q.size() != 0) mismatches++;

    $display("Sent %0d front inserts, %0d back appends, %0d deletes, %0d unused commands.",
             n_front, n_back, n_delete, n_unused);
    $display("Checked %0d dump items; %0d inserts hit a full list; longest list %0d.",
             n_items_checked, n_dropped, max_len);
    if (mismatches == 0) begin
      $display("** ordered_list_insert_delete_engine_unit: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** ordered_list_insert_delete_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/olie_pkg.sv
rtl/core/olie_cell.sv
rtl/core/ordered_list_insert_delete_engine_unit.sv
bench/tb_ordered_list_insert_delete_engine_unit.sv
